// ----- hdl/mvm_pkg.sv -----
// Shared types and constants for the matrix-vector multiplier.
// Used by mvm_mac and matrix_vector_multiply; no dependencies.
package mvm_pkg;

  localparam int unsigned IdxW    = 6;
  localparam int unsigned ValW    = 16;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned SumW    = 40;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned ResLimit = 64;

  localparam logic ACT_WEIGHT = 1'b0;
  localparam logic ACT_VECTOR = 1'b1;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [IdxW-1:0]        row_index;
    logic [IdxW-1:0]        column_index;
    logic signed [ValW-1:0] value;
  } mvm_in_t;

  typedef struct packed {
    logic [IdxW-1:0]        result_row;
    logic signed [SumW-1:0] dot_sum;
    logic                   last_of_run;
  } mvm_out_t;

  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last_col;
    logic            last_row;
    logic [IdxW-1:0] row;
  } mac_tag_t;

  function automatic logic [CfgW-1:0] eff_count(logic [CfgW-1:0] r, logic [CfgW-1:0] lim);
    logic [CfgW-1:0] v;
    v = (r == '0) ? CfgW'(1) : r;
    if (v > lim) v = lim;
    return v;
  endfunction

endpackage

// ----- hdl/mvm_mac.sv -----
// Multiply-accumulate pipeline: product stage, then accumulate and result register.
// Depends on mvm_pkg.
module mvm_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mvm_pkg::mac_tag_t              tag_i,
  input  logic signed [mvm_pkg::ValW-1:0] weight_i,
  input  logic signed [mvm_pkg::ValW-1:0] vector_i,
  output logic                           busy_o,
  output logic                           strobe_o,
  output mvm_pkg::mvm_out_t              res_o
);
  import mvm_pkg::*;

  mac_tag_t               tag_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [SumW-1:0]  acc_q, acc_d;
  logic                    strobe_q;
  mvm_out_t                res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      tag_q    <= tag_i;
      strobe_q <= tag_q.valid & tag_q.last_col;
    end
  end

  assign acc_d = (tag_q.first ? SumW'(0) : acc_q) + SumW'(prod_q);

  always_ff @(posedge clk_i) begin
    prod_q <= weight_i * vector_i;
    if (tag_q.valid) begin
      acc_q <= acc_d;
    end
    if (tag_q.valid && tag_q.last_col) begin
      res_q.result_row  <= tag_q.row;
      res_q.dot_sum     <= acc_d;
      res_q.last_of_run <= tag_q.last_row;
    end
  end

  assign busy_o   = tag_q.valid;
  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

// ----- hdl/matrix_vector_multiply.sv -----
// Matrix-vector multiplier top level: stores, sequencer and configuration.
// Depends on mvm_pkg and mvm_mac.
//
// Usage:
//   Requests enter on start/in_i while busy is low. A weight request writes one
//   matrix entry; a vector request writes one vector element. A load leaves busy
//   low (but for one that starts a pass), so loads may follow every cycle.
//   A vector request at the last column in use starts a product pass: busy
//   rises and one shared 16x16 multiplier with a 40-bit accumulator walks the
//   matrix one entry a cycle, rows x columns entries in all, followed by the
//   read, multiply and accumulate registers.
//   Each row's sum appears on res_o for one cycle with out_strobe_o high, in
//   row order, last_of_run marking the final row.
//   The receiver cannot stall; results are never held.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i) writes rows and columns in
//   use; the user must write it only while idle, the block does not enforce it.
//   Reset clears the sequencer and sets 64 rows and 64 columns; the stores
//   are not cleared and must be written before use.
module matrix_vector_multiply #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  mvm_pkg::mvm_in_t         in_i,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [mvm_pkg::CfgW-1:0] cfg_data_i,
  output logic                     out_strobe_o,
  output mvm_pkg::mvm_out_t        res_o
);
  import mvm_pkg::*;

  localparam int unsigned Depth   = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned VecW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RowLim  = (MAX_ROWS < ResLimit) ? MAX_ROWS : ResLimit;
  localparam int unsigned ColLim  = (MAX_COLS < ResLimit) ? MAX_COLS : ResLimit;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CfgW-1:0] rows_cfg_q, cols_cfg_q;
  logic [CfgW-1:0] rows_eff, cols_eff;
  logic [IdxW-1:0] row_q, row_d, col_q, col_d;
  mac_tag_t        tag_d, tag_q;
  logic            accept, last_col, last_row, mac_busy;
  logic            w_we, v_we;
  logic [AddrW-1:0] w_waddr, w_raddr;
  logic [VecW-1:0]  v_waddr, v_raddr;

  logic signed [ValW-1:0] w_mem [Depth];
  logic signed [ValW-1:0] v_mem [MAX_COLS];
  logic signed [ValW-1:0] w_rd_q, v_rd_q;

  assign rows_eff = eff_count(rows_cfg_q, CfgW'(RowLim));
  assign cols_eff = eff_count(cols_cfg_q, CfgW'(ColLim));

  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= CfgW'(64);
      cols_cfg_q <= CfgW'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROWS: rows_cfg_q <= cfg_data_i;
        CFG_COLS: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_we = accept && (in_i.action == ACT_WEIGHT) &&
                (32'(in_i.row_index) < MAX_ROWS) && (32'(in_i.column_index) < MAX_COLS);
  assign v_we = accept && (in_i.action == ACT_VECTOR) &&
                (32'(in_i.column_index) < MAX_COLS);
  assign w_waddr = AddrW'(32'(in_i.row_index) * MAX_COLS + 32'(in_i.column_index));
  assign v_waddr = VecW'(in_i.column_index);
  assign w_raddr = AddrW'(32'(row_q) * MAX_COLS + 32'(col_q));
  assign v_raddr = VecW'(col_q);

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_waddr] <= in_i.value;
    end
    w_rd_q <= w_mem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      v_mem[v_waddr] <= in_i.value;
    end
    v_rd_q <= v_mem[v_raddr];
  end

  assign last_col = ({1'b0, col_q} == cols_eff - CfgW'(1));
  assign last_row = ({1'b0, row_q} == rows_eff - CfgW'(1));

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    tag_d   = '0;
    unique case (state_q)
      ST_IDLE: begin
        row_d = '0;
        col_d = '0;
        if (v_we && ({1'b0, in_i.column_index} == cols_eff - CfgW'(1))) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        tag_d.valid    = 1'b1;
        tag_d.first    = (col_q == '0);
        tag_d.last_col = last_col;
        tag_d.last_row = last_row;
        tag_d.row      = row_q;
        if (last_col) begin
          col_d = '0;
          if (last_row) begin
            state_d = ST_DRAIN;
          end else begin
            row_d = row_q + IdxW'(1);
          end
        end else begin
          col_d = col_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        if (!tag_q.valid && !mac_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      tag_q   <= tag_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  mvm_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag_q),
    .weight_i (w_rd_q),
    .vector_i (v_rd_q),
    .busy_o   (mac_busy),
    .strobe_o (out_strobe_o),
    .res_o    (res_o)
  );

endmodule
